### hw/rtl/lmss_pkg.sv
// Shared types, codes and constants of the LED matrix scan serializer.
package lmss_pkg;

	localparam int SCAN_ROWS   = 16;
	localparam int FRAME_BYTES = 32;
	localparam int FRAME_WORDS = 8;
	localparam int WORD_BITS   = 32;

	typedef enum logic [1:0] {
		KIND_ADDR = 2'd0,
		KIND_STOP = 2'd1,
		KIND_DATA = 2'd2,
		KIND_TICK = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REPLY_NONE = 2'd0,
		REPLY_ACK  = 2'd1,
		REPLY_DONE = 2'd2
	} reply_t;

	localparam logic DIR_WRITE = 1'b0;

	// One byte write into the frame store.
	typedef struct packed {
		logic       en;
		logic [4:0] idx;
		logic [7:0] data;
	} frame_wr_t;

	localparam logic [15:0] GREEN_INIT [FRAME_WORDS] = '{
		16'hAE00, 16'hA800, 16'hA800, 16'hAEEE,
		16'h00AA, 16'hEAEE, 16'hA4AA, 16'hEAEE
	};

	// Per output bit: bit 3 picks red, bits 2..0 the source bit.
	localparam logic [3:0] PERM [16] = '{
		4'h4, 4'hC, 4'h5, 4'hD, 4'h6, 4'hE, 4'h7, 4'hF,
		4'hB, 4'h3, 4'hA, 4'h2, 4'h9, 4'h1, 4'h8, 4'h0
	};

	// Row select bit at 16 + row over the inverted, permuted pixel pair.
	function automatic logic [WORD_BITS-1:0] make_word(input logic [7:0] red,
			input logic [7:0] green, input logic [3:0] row);
		logic [15:0]          pix;
		logic [7:0]           src;
		logic [WORD_BITS-1:0] word;
		for (int k = 0; k < 16; k++) begin
			src    = PERM[k][3] ? red : green;
			pix[k] = src[PERM[k][2:0]];
		end
		word              = '0;
		word[15:0]        = ~pix;
		word[{1'b1, row}] = 1'b1;
		return word;
	endfunction

	localparam logic [WORD_BITS-1:0] ROW_WORD_RST = make_word(8'h00, GREEN_INIT[0][15:8], 4'd0);

endpackage

### hw/rtl/lmss_if.sv
// Handshake channels: bus/scan items in, reply and wire levels out.
interface lmss_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic       direction;
	logic [7:0] data_byte;

	modport source(output valid, kind, direction, data_byte, input ready);
	modport sink(input valid, kind, direction, data_byte, output ready);
endinterface

interface lmss_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] bus_reply;
	logic       serial_clock;
	logic       short_pulse;
	logic       latch_pulse;

	modport source(output valid, bus_reply, serial_clock, short_pulse, latch_pulse,
		input ready);
	modport sink(input valid, bus_reply, serial_clock, short_pulse, latch_pulse,
		output ready);
endinterface

### hw/rtl/lmss_frame_store.sv
// Red and green frame registers with byte writes and row word formation.
module lmss_frame_store
	import lmss_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  frame_wr_t            wr,
	input  logic [3:0]           row,
	output logic [WORD_BITS-1:0] word
);

	logic [15:0] red_q   [FRAME_WORDS];
	logic [15:0] green_q [FRAME_WORDS];

	logic [2:0]  wr_word;
	logic [15:0] red_sel, green_sel;

	assign wr_word = wr.idx[3:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAME_WORDS; i++) begin
				red_q[i]   <= '0;
				green_q[i] <= GREEN_INIT[i];
			end
		end else if (wr.en) begin
			// even byte index fills the high byte
			if (wr.idx[4]) begin
				if (wr.idx[0]) green_q[wr_word][7:0]  <= wr.data;
				else           green_q[wr_word][15:8] <= wr.data;
			end else begin
				if (wr.idx[0]) red_q[wr_word][7:0]  <= wr.data;
				else           red_q[wr_word][15:8] <= wr.data;
			end
		end
	end

	always_comb begin
		red_sel   = red_q[row[2:0]];
		green_sel = green_q[row[2:0]];
		// rows 0..7 use the high bytes, rows 8..15 the low bytes
		if (row[3]) word = make_word(red_sel[7:0], green_sel[7:0], row);
		else        word = make_word(red_sel[15:8], green_sel[15:8], row);
	end

endmodule

### hw/rtl/led_matrix_scan_serializer_core.sv
// One item per clock: every bus event or scan tick is accepted as one item and its
// result appears in the output register on the following cycle. The input is ready
// whenever the output register is empty or its result is being taken, so with a
// consuming sink the block sustains one item per cycle; only output back-pressure stalls
// it. Bytes written on the bus land in the frame at once, but a row being shifted keeps
// the word captured when that row began (65 ticks per row: 64 bit ticks and one idle).
module led_matrix_scan_serializer_core
	import lmss_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	lmss_cmd_if.sink  cmd,
	lmss_rsp_if.source rsp
);

	logic                 accept;
	kind_t                kind;
	frame_wr_t            frame_wr;
	logic [WORD_BITS-1:0] next_word;

	logic [4:0]           byte_index_q;
	logic                 bytes_full_q;
	logic [3:0]           scan_row_q;
	logic [6:0]           tick_q;
	logic                 clock_level_q;
	logic [WORD_BITS-1:0] row_word_q;

	logic                 out_valid_q;
	reply_t               reply_q;
	logic                 clock_q, short_q, latch_q;

	logic                 cur_bit;
	logic [3:0]           next_row;
	reply_t               reply_d;
	logic                 clock_d, short_d, latch_d;

	assign cmd.ready = !out_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;
	assign kind      = kind_t'(cmd.kind);
	assign next_row  = scan_row_q + 4'd1;
	assign cur_bit   = row_word_q[tick_q[5:1]];

	assign frame_wr.en   = accept && kind == KIND_DATA;
	assign frame_wr.idx  = byte_index_q;
	assign frame_wr.data = cmd.data_byte;

	lmss_frame_store u_frames (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (frame_wr),
		.row    (next_row),
		.word   (next_word)
	);

	always_comb begin
		reply_d = REPLY_NONE;
		clock_d = clock_level_q;
		short_d = 1'b0;
		latch_d = 1'b0;
		case (kind)
			KIND_ADDR: reply_d = REPLY_ACK;
			KIND_STOP: reply_d = REPLY_DONE;
			KIND_DATA: reply_d = bytes_full_q ? REPLY_DONE : REPLY_ACK;
			KIND_TICK: begin
				if (!tick_q[6]) begin
					if (!tick_q[0]) begin
						// a one bit is a short low pulse that ends high
						clock_d = cur_bit;
						short_d = cur_bit;
					end else begin
						if (!cur_bit) clock_d = 1'b1;
						latch_d = &tick_q[5:0];
					end
				end
			end
			default: reply_d = REPLY_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q  <= '0;
			bytes_full_q  <= 1'b0;
			scan_row_q    <= '0;
			tick_q        <= '0;
			clock_level_q <= 1'b1;
			row_word_q    <= ROW_WORD_RST;
		end else if (accept) begin
			clock_level_q <= clock_d;
			case (kind)
				KIND_ADDR: begin
					if (cmd.direction == DIR_WRITE) begin
						byte_index_q <= '0;
						bytes_full_q <= 1'b0;
					end
				end
				KIND_DATA: begin
					byte_index_q <= byte_index_q + 5'd1;
					if (&byte_index_q) bytes_full_q <= 1'b1;
				end
				KIND_TICK: begin
					if (!tick_q[6]) begin
						tick_q <= tick_q + 7'd1;
					end else begin
						tick_q     <= '0;
						scan_row_q <= next_row;
						row_word_q <= next_word;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.ready) out_valid_q <= cmd.valid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			reply_q <= reply_d;
			clock_q <= clock_d;
			short_q <= short_d;
			latch_q <= latch_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.bus_reply    = reply_q;
	assign rsp.serial_clock = clock_q;
	assign rsp.short_pulse  = short_q;
	assign rsp.latch_pulse  = latch_q;

endmodule

### hw/rtl/lmss_checker.sv
// Port-level checks of the scan serializer and their binding to the top level.
module lmss_checker
	import lmss_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic [1:0] cmd_kind,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] rsp_bus_reply,
	input logic       rsp_serial_clock,
	input logic       rsp_short_pulse,
	input logic       rsp_latch_pulse
);

	// a stop is answered with complete in the very next result
	a_stop_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_kind == KIND_STOP
		|=> rsp_valid && rsp_bus_reply == REPLY_DONE)
		else $error("stop not answered with complete");

	// latch strobe falls on an odd scan tick only
	a_latch_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_latch_pulse
		|-> !rsp_short_pulse && rsp_bus_reply == REPLY_NONE && rsp_serial_clock)
		else $error("latch strobe with other activity");

	a_pulse_ends_high: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_short_pulse
		|-> rsp_serial_clock && rsp_bus_reply == REPLY_NONE)
		else $error("short pulse without wire high");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready
		|=> rsp_valid && $stable(rsp_bus_reply) && $stable(rsp_serial_clock)
			&& $stable(rsp_short_pulse) && $stable(rsp_latch_pulse))
		else $error("stalled result changed");

endmodule

bind led_matrix_scan_serializer_core lmss_checker u_lmss_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.cmd_kind         (cmd.kind),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_bus_reply    (rsp.bus_reply),
	.rsp_serial_clock (rsp.serial_clock),
	.rsp_short_pulse  (rsp.short_pulse),
	.rsp_latch_pulse  (rsp.latch_pulse)
);

### tb/led_matrix_scan_serializer_core_tb.sv
// Self-checking testbench for the LED matrix scan serializer core.
`timescale 1ns / 100ps

module led_matrix_scan_serializer_core_tb
	import lmss_pkg::*;
();

	localparam logic DIR_READ     = 1'b1;
	localparam int   RANDOM_ITEMS = 1250;
	localparam int   CYCLE_LIMIT  = 200000;
	localparam int   HOLD_CYCLES  = 300;
	localparam int   DRAIN_CYCLES = 10;

	typedef struct packed {
		reply_t reply;
		logic   sclk;
		logic   sp;
		logic   lp;
	} scan_out_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       dir;
		logic [7:0] data;
		logic       typed;
		scan_out_t  want;
	} stim_row_t;

	localparam scan_out_t NO_WANT = '{REPLY_NONE, 1'b0, 1'b0, 1'b0};

	// typed rows: reply and wire level right after reset, before any tick
	localparam stim_row_t DIRECTED [20] = '{
		'{KIND_ADDR, DIR_WRITE, 8'h00, 1'b1, '{REPLY_ACK,  1'b1, 1'b0, 1'b0}},
		'{KIND_STOP, DIR_READ,  8'hFF, 1'b1, '{REPLY_DONE, 1'b1, 1'b0, 1'b0}},
		'{KIND_ADDR, DIR_READ,  8'h00, 1'b1, '{REPLY_ACK,  1'b1, 1'b0, 1'b0}},
		'{KIND_DATA, DIR_WRITE, 8'h00, 1'b1, '{REPLY_ACK,  1'b1, 1'b0, 1'b0}},
		'{KIND_DATA, DIR_WRITE, 8'hFF, 1'b1, '{REPLY_ACK,  1'b1, 1'b0, 1'b0}},
		'{KIND_DATA, DIR_READ,  8'h5A, 1'b0, NO_WANT},
		'{KIND_TICK, DIR_WRITE, 8'h00, 1'b0, NO_WANT},
		'{KIND_TICK, DIR_READ,  8'hFF, 1'b0, NO_WANT},
		'{KIND_TICK, DIR_WRITE, 8'h00, 1'b0, NO_WANT},
		'{KIND_TICK, DIR_WRITE, 8'h00, 1'b0, NO_WANT},
		'{KIND_ADDR, DIR_WRITE, 8'h00, 1'b0, NO_WANT},
		'{KIND_DATA, DIR_WRITE, 8'h80, 1'b0, NO_WANT},
		'{KIND_DATA, DIR_WRITE, 8'h01, 1'b0, NO_WANT},
		'{KIND_STOP, DIR_WRITE, 8'h00, 1'b0, NO_WANT},
		'{KIND_TICK, DIR_READ,  8'hA5, 1'b0, NO_WANT},
		'{KIND_TICK, DIR_WRITE, 8'h00, 1'b0, NO_WANT},
		'{KIND_ADDR, DIR_READ,  8'hFF, 1'b0, NO_WANT},
		'{KIND_DATA, DIR_WRITE, 8'h7F, 1'b0, NO_WANT},
		'{KIND_STOP, DIR_READ,  8'h00, 1'b0, NO_WANT},
		'{KIND_TICK, DIR_WRITE, 8'h00, 1'b0, NO_WANT}
	};

	// pixel source per output bit: bit 3 = red byte, bits 2..0 = bit index
	localparam logic [3:0] PIX_SRC [16] = '{
		4'h4, 4'hC, 4'h5, 4'hD, 4'h6, 4'hE, 4'h7, 4'hF,
		4'hB, 4'h3, 4'hA, 4'h2, 4'h9, 4'h1, 4'h8, 4'h0
	};

	localparam logic [15:0] GREEN_BOOT [8] = '{
		16'hAE00, 16'hA800, 16'hA800, 16'hAEEE,
		16'h00AA, 16'hEAEE, 16'hA4AA, 16'hEAEE
	};

	logic clk;
	logic arst_n;

	lmss_cmd_if cmd_ch ();
	lmss_rsp_if rsp_ch ();

	led_matrix_scan_serializer_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// predictor state
	logic [15:0] red_mem [8];
	logic [15:0] green_mem [8];
	logic [4:0]  wr_idx;
	logic        frame_full;
	logic [3:0]  row_sel;
	logic [6:0]  row_tick;
	logic        wire_level;
	logic [31:0] row_bits;

	scan_out_t pending_out [$];
	int        mismatch_cnt  = 0;
	int        sent_cnt      = 0;
	int        cycle_cnt     = 0;
	int        send_idle_pct = 0;
	int        sink_stall_pct = 0;
	int        hold_request  = 0;
	int        hold_left     = 0;

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [31:0] row_pattern(input logic [3:0] r);
		logic [7:0]  rb;
		logic [7:0]  gb;
		logic [7:0]  s;
		logic [15:0] px;
		rb = r[3] ? red_mem[r[2:0]][7:0] : red_mem[r[2:0]][15:8];
		gb = r[3] ? green_mem[r[2:0]][7:0] : green_mem[r[2:0]][15:8];
		for (int k = 0; k < 16; k++) begin
			s     = PIX_SRC[k][3] ? rb : gb;
			px[k] = s[PIX_SRC[k][2:0]];
		end
		return {16'h0000, ~px} | (32'd1 << (16 + r));
	endfunction

	task automatic predictor_reset();
		for (int i = 0; i < 8; i++) begin
			red_mem[i]   = 16'h0000;
			green_mem[i] = GREEN_BOOT[i];
		end
		wr_idx     = '0;
		frame_full = 1'b0;
		row_sel    = '0;
		row_tick   = '0;
		wire_level = 1'b1;
		row_bits   = row_pattern(4'd0);
	endtask

	task automatic predict_scan_item(input logic [1:0] k, input logic d, input logic [7:0] b,
			output scan_out_t o);
		logic       bitv;
		logic [2:0] w;
		o = NO_WANT;
		case (k)
			KIND_ADDR: begin
				if (d == DIR_WRITE) begin
					wr_idx     = '0;
					frame_full = 1'b0;
				end
				o.reply = REPLY_ACK;
			end
			KIND_STOP: o.reply = REPLY_DONE;
			KIND_DATA: begin
				w = wr_idx[3:1];
				if (wr_idx[4]) begin
					if (wr_idx[0]) green_mem[w][7:0] = b;
					else green_mem[w][15:8] = b;
				end else begin
					if (wr_idx[0]) red_mem[w][7:0] = b;
					else red_mem[w][15:8] = b;
				end
				o.reply = frame_full ? REPLY_DONE : REPLY_ACK;
				if (wr_idx == 5'd31)
					frame_full = 1'b1;
				wr_idx = wr_idx + 5'd1;
			end
			default: begin
				if (row_tick < 7'd64) begin
					bitv = row_bits[row_tick[5:1]];
					if (!row_tick[0]) begin
						// one bit: short low pulse, wire ends high
						if (bitv) begin
							o.sp       = 1'b1;
							wire_level = 1'b1;
						end else begin
							wire_level = 1'b0;
						end
					end else begin
						if (!bitv)
							wire_level = 1'b1;
						if (row_tick == 7'd63)
							o.lp = 1'b1;
					end
					row_tick = row_tick + 7'd1;
				end else begin
					// idle tick: next row word is captured here
					row_sel  = row_sel + 4'd1;
					row_tick = '0;
					row_bits = row_pattern(row_sel);
				end
			end
		endcase
		o.sclk = wire_level;
	endtask

	// entered and left at a falling edge
	task automatic push_cmd(input logic [1:0] k, input logic d, input logic [7:0] b,
			input logic typed, input scan_out_t want);
		scan_out_t predicted;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid = 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid     = 1'b1;
		cmd_ch.kind      = k;
		cmd_ch.direction = d;
		cmd_ch.data_byte = b;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		predict_scan_item(k, d, b, predicted);
		pending_out.push_back(typed ? want : predicted);
		sent_cnt++;
		@(negedge clk);
	endtask

	task automatic push_rand(input logic [1:0] k);
		push_cmd(k, 1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, NO_WANT);
	endtask

	task automatic random_chunk();
		int c;
		int n;
		c = $urandom_range(99);
		if (c < 50) begin
			repeat ($urandom_range(140, 1)) push_rand(KIND_TICK);
		end else if (c < 85) begin
			// frame load: address write, bytes with occasional ticks, mostly a stop
			push_cmd(KIND_ADDR, DIR_WRITE, 8'($urandom_range(255)), 1'b0, NO_WANT);
			c = $urandom_range(99);
			if (c < 60) n = 32;
			else if (c < 75) n = $urandom_range(36, 33);
			else n = $urandom_range(31);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(9) == 0)
					push_rand(KIND_TICK);
				push_rand(KIND_DATA);
			end
			if ($urandom_range(9) != 0)
				push_rand(KIND_STOP);
		end else begin
			repeat ($urandom_range(6, 1)) push_rand(2'($urandom_range(3)));
		end
	endtask

	task automatic wait_drained();
		while (pending_out.size() != 0) @(negedge clk);
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			rsp_ch.ready = 1'b0;
			hold_left--;
		end else begin
			rsp_ch.ready = ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		scan_out_t got;
		scan_out_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = '{reply_t'(rsp_ch.bus_reply), rsp_ch.serial_clock, rsp_ch.short_pulse,
				rsp_ch.latch_pulse};
			if (pending_out.size() == 0) begin
				$display("%0t: unexpected item: reply %0d clk %b short %b latch %b",
					$time, got.reply, got.sclk, got.sp, got.lp);
				mismatch_cnt++;
			end else begin
				want = pending_out.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch: expected reply %0d clk %b short %b latch %b",
						$time, want.reply, want.sclk, want.sp, want.lp);
					$display("%0t:           actual   reply %0d clk %b short %b latch %b",
						$time, got.reply, got.sclk, got.sp, got.lp);
					mismatch_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int phase_end;
		arst_n           = 1'b0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.kind      = KIND_ADDR;
		cmd_ch.direction = DIR_WRITE;
		cmd_ch.data_byte = 8'h00;
		predictor_reset();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < 20; i++)
			push_cmd(DIRECTED[i].kind, DIRECTED[i].dir, DIRECTED[i].data,
				DIRECTED[i].typed, DIRECTED[i].want);
		cmd_ch.valid = 1'b0;
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin send_idle_pct = 77; sink_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  sink_stall_pct = 77; end
				default: begin send_idle_pct = 14; sink_stall_pct = 14; end
			endcase
			// back-to-back items against a long output hold-off
			if (p == 0)
				hold_request = HOLD_CYCLES;
			phase_end = sent_cnt + RANDOM_ITEMS / 4;
			while (sent_cnt < phase_end) random_chunk();
			cmd_ch.valid = 1'b0;
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && pending_out.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### sim.f
hw/rtl/lmss_pkg.sv
hw/rtl/lmss_if.sv
hw/rtl/lmss_frame_store.sv
hw/rtl/led_matrix_scan_serializer_core.sv
hw/rtl/lmss_checker.sv
tb/led_matrix_scan_serializer_core_tb.sv
